// File: design/general_matrix_multiply_top_defines.svh
// Assertion macros used by the matrix multiply RTL.
`ifndef GENERAL_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define GENERAL_MATRIX_MULTIPLY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GMM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/gmm_pkg.sv
// Types and constants of the matrix multiply block.
package gmm_pkg;

   localparam int VAL_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = 2 * VAL_W;
   localparam int ACC_W      = PROD_W + 4;
   localparam int RND_W      = ACC_W - FRAC_W;
   localparam int ROUND_HALF = 1 << (FRAC_W - 1);
   localparam int ROW_W      = 3;
   localparam int REQ_W      = 2;
   localparam int CFG_DIM_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
   localparam logic [REQ_W-1:0] REQ_LOAD_C = 2'd2;
   localparam logic [REQ_W-1:0] REQ_START  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_C_SCALE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_P_SCALE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_M      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_N      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_K     = 3'd6;

   localparam logic signed [VAL_W-1:0] P_SCALE_RESET = 32'sh0001_0000;
   localparam logic [CFG_DIM_W-1:0]    DIM_RESET     = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   typedef struct packed {
      logic [REQ_W-1:0]        req_type;
      logic [ROW_W-1:0]        row;
      logic [ROW_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [ROW_W-1:0]        out_row;
      logic [ROW_W-1:0]        out_col;
      logic signed [VAL_W-1:0] out_value;
      logic                    last;
   } rsp_item_type;

endpackage

// File: design/gmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/general_matrix_multiply_top.sv
// Matrix multiply C = c_scale*C + product_scale*op(A)*op(B), Q16.16, with
// the A, B and C matrices held in three RAMs of MAX_DIM*MAX_DIM words. Load
// beats are taken one per cycle and written straight into their RAM. A start
// beat runs the whole product through one multiply-accumulate pipeline that
// reads one A and one B word per cycle, M*N*K pairs for a run, and then
// drains the pipeline; each C entry goes through a second multiply stage,
// is sent out in column-major order and written back. The input is stalled
// for the whole run, and a stall on the result side freezes the pipeline
// until the waiting result is taken.
`include "general_matrix_multiply_top_defines.svh"

module general_matrix_multiply_top #(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  gmm_pkg::req_item_type                 req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output gmm_pkg::rsp_item_type                 rsp_data,
   input  logic                                  csr_we,
   input  logic [gmm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [gmm_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   import gmm_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM);
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SAT_W  = (DATA_WIDTH > VAL_W) ? VAL_W : DATA_WIDTH;

   localparam logic signed [RND_W-1:0] SAT_MAX =
      {{(RND_W - SAT_W + 1){1'b0}}, {(SAT_W - 1){1'b1}}};
   localparam logic signed [RND_W-1:0] SAT_MIN =
      {{(RND_W - SAT_W + 1){1'b1}}, {(SAT_W - 1){1'b0}}};

   typedef struct packed {
      logic             first;
      logic             lastk;
      logic             last;
      logic [DIM_W-1:0] r;
      logic [DIM_W-1:0] c;
   } tag_type;

   function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_DIM_W-1:0] d);
      if (d == '0) begin
         return '0;
      end else if (d > MAX_DIM) begin
         return DIM_W'(MAX_DIM - 1);
      end else begin
         return DIM_W'(d - 1'b1);
      end
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [DIM_W-1:0] rr,
                                                 input logic [DIM_W-1:0] cc);
      return ADDR_W'(int'(rr) * MAX_DIM + int'(cc));
   endfunction

   // Round half up from Q32.32 to Q16.16, then clamp to the result width.
   function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] biased;
      logic signed [RND_W-1:0] sh;
      biased = x + ACC_W'(ROUND_HALF);
      sh = RND_W'(biased >>> FRAC_W);
      if (sh > SAT_MAX) begin
         return VAL_W'(SAT_MAX);
      end else if (sh < SAT_MIN) begin
         return VAL_W'(SAT_MIN);
      end else begin
         return VAL_W'(sh);
      end
   endfunction

   // Configuration registers.
   logic                    ta_ff, tb_ff;
   logic signed [VAL_W-1:0] c_scale_ff, p_scale_ff;
   logic [CFG_DIM_W-1:0]    rows_ff, cols_ff, inner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ta_ff      <= 1'b0;
         tb_ff      <= 1'b0;
         c_scale_ff <= '0;
         p_scale_ff <= P_SCALE_RESET;
         rows_ff    <= DIM_RESET;
         cols_ff    <= DIM_RESET;
         inner_ff   <= DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRANSPOSE_A: ta_ff      <= csr_wdata[0];
            CSR_TRANSPOSE_B: tb_ff      <= csr_wdata[0];
            CSR_C_SCALE:     c_scale_ff <= VAL_W'(csr_wdata);
            CSR_P_SCALE:     p_scale_ff <= VAL_W'(csr_wdata);
            CSR_ROWS_M:      rows_ff    <= csr_wdata[CFG_DIM_W-1:0];
            CSR_COLS_N:      cols_ff    <= csr_wdata[CFG_DIM_W-1:0];
            CSR_INNER_K:     inner_ff   <= csr_wdata[CFG_DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   logic [DIM_W-1:0] m_last, n_last, k_last;
   assign m_last = dim_last(rows_ff);
   assign n_last = dim_last(cols_ff);
   assign k_last = dim_last(inner_ff);

   // Control state and pipeline handshake.
   state_type        state_ff, state_in;
   logic [DIM_W-1:0] cnt_r_ff, cnt_c_ff, cnt_i_ff;
   logic             req_acc, start_acc, adv, issue, issue_done, pipe_busy;
   logic             p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff, p5_valid_ff;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign start_acc = req_acc && (req_data.req_type == REQ_START);

   // The whole pipeline, RAM read registers included, holds while a result waits.
   assign adv        = !(rsp_valid_ff && rsp_stall);
   assign issue      = (state_ff == ST_RUN) && adv;
   assign issue_done = (cnt_i_ff == k_last) && (cnt_r_ff == m_last) && (cnt_c_ff == n_last);
   assign pipe_busy  = p1_valid_ff || p2_valid_ff || p3_valid_ff || p4_valid_ff
                       || p5_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_acc) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue && issue_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy && !rsp_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_r_ff <= '0;
         cnt_c_ff <= '0;
         cnt_i_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (start_acc) begin
            cnt_r_ff <= '0;
            cnt_c_ff <= '0;
            cnt_i_ff <= '0;
         end else if (issue) begin
            if (cnt_i_ff == k_last) begin
               cnt_i_ff <= '0;
               if (cnt_r_ff == m_last) begin
                  cnt_r_ff <= '0;
                  cnt_c_ff <= cnt_c_ff + 1'b1;
               end else begin
                  cnt_r_ff <= cnt_r_ff + 1'b1;
               end
            end else begin
               cnt_i_ff <= cnt_i_ff + 1'b1;
            end
         end
      end
   end

   // Loads and operand addressing.
   logic              ld_ok, a_we, b_we, ld_c_we, c_we, c_re, wb_en;
   logic [ADDR_W-1:0] ld_addr, a_raddr, b_raddr, c_raddr, c_waddr;
   logic [VAL_W-1:0]  a_rd, b_rd, c_rd, c_wdata;
   tag_type           issue_tag;

   assign ld_ok   = req_acc && (req_data.req_type != REQ_START)
                    && (int'(req_data.row) < MAX_DIM) && (int'(req_data.col) < MAX_DIM);
   assign ld_addr = ADDR_W'(int'(req_data.row) * MAX_DIM + int'(req_data.col));

   always_comb begin
      a_we    = 1'b0;
      b_we    = 1'b0;
      ld_c_we = 1'b0;
      case (req_data.req_type)
         REQ_LOAD_A: a_we    = ld_ok;
         REQ_LOAD_B: b_we    = ld_ok;
         REQ_LOAD_C: ld_c_we = ld_ok;
         default: begin
         end
      endcase
   end

   assign a_raddr = ta_ff ? addr_of(cnt_i_ff, cnt_r_ff) : addr_of(cnt_r_ff, cnt_i_ff);
   assign b_raddr = tb_ff ? addr_of(cnt_c_ff, cnt_i_ff) : addr_of(cnt_i_ff, cnt_c_ff);
   assign c_raddr = addr_of(cnt_r_ff, cnt_c_ff);
   assign c_re    = issue && (cnt_i_ff == k_last);

   assign issue_tag.first = (cnt_i_ff == '0);
   assign issue_tag.lastk = (cnt_i_ff == k_last);
   assign issue_tag.last  = (cnt_r_ff == m_last) && (cnt_c_ff == n_last);
   assign issue_tag.r     = cnt_r_ff;
   assign issue_tag.c     = cnt_c_ff;

   gmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (ld_addr),
      .wr_data (req_data.value),
      .rd_en   (issue),
      .rd_addr (a_raddr),
      .rd_data (a_rd)
   );

   gmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (ld_addr),
      .wr_data (req_data.value),
      .rd_en   (issue),
      .rd_addr (b_raddr),
      .rd_data (b_rd)
   );

   gmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_c_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_en   (c_re),
      .rd_addr (c_raddr),
      .rd_data (c_rd)
   );

   // Pipeline: P1 RAM data, P2 product, P3 dot sum, P4 rounded dot,
   // P5 scaled terms, then the output register and C write-back.
   tag_type                  p1_tag_ff, p2_tag_ff, p3_tag_ff, p4_tag_ff, p5_tag_ff;
   logic signed [VAL_W-1:0]  a_val, b_val;
   logic signed [PROD_W-1:0] mac_prod, p2_prod_ff;
   logic signed [VAL_W-1:0]  p2_cold_ff, p3_cold_ff, p4_cold_ff, p4_dot_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, p3_sum_ff, fin_sum;
   logic signed [PROD_W-1:0] p5_mc_in, p5_mp_in, p5_mc_ff, p5_mp_ff;

   assign a_val    = a_rd;
   assign b_val    = b_rd;
   assign mac_prod = a_val * b_val;
   assign acc_in   = (p2_tag_ff.first ? '0 : acc_ff) + ACC_W'(p2_prod_ff);
   assign p5_mc_in = c_scale_ff * p4_cold_ff;
   assign p5_mp_in = p_scale_ff * p4_dot_ff;
   assign fin_sum  = ACC_W'(p5_mc_ff) + ACC_W'(p5_mp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         p5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff  <= issue;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff && p2_tag_ff.lastk;
         p4_valid_ff  <= p3_valid_ff;
         p5_valid_ff  <= p4_valid_ff;
         rsp_valid_ff <= p5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_tag_ff  <= issue_tag;
         p2_tag_ff  <= p1_tag_ff;
         p2_prod_ff <= mac_prod;
         if (p1_tag_ff.lastk) begin
            p2_cold_ff <= c_rd;
         end
         if (p2_valid_ff) begin
            acc_ff <= acc_in;
         end
         p3_tag_ff  <= p2_tag_ff;
         p3_sum_ff  <= acc_in;
         p3_cold_ff <= p2_cold_ff;
         p4_tag_ff  <= p3_tag_ff;
         p4_dot_ff  <= round_sat(p3_sum_ff);
         p4_cold_ff <= p3_cold_ff;
         p5_tag_ff  <= p4_tag_ff;
         p5_mc_ff   <= p5_mc_in;
         p5_mp_ff   <= p5_mp_in;
         rsp_ff.out_row   <= ROW_W'(p5_tag_ff.r);
         rsp_ff.out_col   <= ROW_W'(p5_tag_ff.c);
         rsp_ff.out_value <= round_sat(fin_sum);
         rsp_ff.last      <= p5_tag_ff.last;
      end
   end

   // Each new entry is written back as it enters the output register.
   assign wb_en   = adv && p5_valid_ff;
   assign c_we    = ld_c_we || wb_en;
   assign c_waddr = wb_en ? addr_of(p5_tag_ff.r, p5_tag_ff.c) : ld_addr;
   assign c_wdata = wb_en ? round_sat(fin_sum) : req_data.value;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `GMM_ASSERT_IMPLY(a_idle_empty, clock, reset, state_ff == ST_IDLE, !pipe_busy && !rsp_valid_ff, "pipeline not empty while idle")
   `GMM_ASSERT_IMPLY(a_last_drain, clock, reset, rsp_valid_ff && rsp_ff.last, state_ff == ST_DRAIN, "final entry shown before issue ended")
   `GMM_ASSERT_IMPLY(a_load_idle, clock, reset, a_we || b_we || ld_c_we, state_ff == ST_IDLE, "load written during a run")
   `GMM_ASSERT_IMPLY(a_wb_source, clock, reset, c_we && state_ff != ST_IDLE, p5_valid_ff && !ld_c_we, "C write during a run without a result")
   `GMM_ASSERT_NEXT(a_last_flush, clock, reset, rsp_valid_ff && !rsp_stall && rsp_ff.last, !rsp_valid_ff && !pipe_busy, "entries left after the final one")

endmodule
